// ===== sv/kmp_pkg.sv =====
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared types, codes and key tables for the keyboard matrix port.
// ----------------------------------------------------------------------------
package kmp_pkg;

  // Matrix geometry
  localparam int unsigned ROWS     = 8;
  localparam int unsigned COLS     = 5;
  localparam int unsigned ROW_W    = $clog2(ROWS);
  localparam int unsigned COL_W    = $clog2(COLS);

  // Item opcodes
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Fixed bits of a port read: bit 7 high, bit 6 low, bit 5 high
  localparam logic [2:0] READ_TOP = 3'b101;
  localparam logic [COLS-1:0] ROW_RELEASED = '1;

  // Host character codes that get translated
  localparam logic [6:0] CH_NONE  = 7'h00;
  localparam logic [6:0] CH_BS    = 7'h08;  // backspace
  localparam logic [6:0] CH_TAB   = 7'h09;
  localparam logic [6:0] CH_CR    = 7'h0d;  // return
  localparam logic [6:0] CH_DQ    = 7'h22;  // double quote
  localparam logic [6:0] CH_ENTER = 7'h65;  // 'e'
  localparam logic [6:0] CH_P     = 7'h50;

  // Positions of the two shift keys
  localparam logic [ROW_W-1:0] CAPS_ROW = 3'd0;
  localparam logic [COL_W-1:0] CAPS_COL = 3'd0;
  localparam logic [ROW_W-1:0] SYM_ROW  = 3'd7;
  localparam logic [COL_W-1:0] SYM_COL  = 3'd1;

  typedef struct packed {
    logic       opcode;
    logic [6:0] key_code;
    logic       key_down;
    logic       shift_flag;
    logic       alt_flag;
    logic [15:0] port_address;
  } in_item_t;

  // Translated key event handed to the matrix
  typedef struct packed {
    logic       valid;
    logic [6:0] code;
    logic       down;
    logic       shift;
    logic       alt;
  } key_event_t;

  typedef struct packed {
    logic             hit;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } key_loc_t;

  function automatic key_loc_t mk_loc(input int unsigned row, input int unsigned col);
    key_loc_t l;
    l.hit = 1'b1;
    l.row = ROW_W'(row);
    l.col = COL_W'(col);
    return l;
  endfunction

  // Translate a host key event into a matrix key event
  function automatic key_event_t translate(input logic [6:0] code, input logic down,
                                           input logic shift, input logic alt);
    key_event_t e;
    e.valid = 1'b1;
    e.code  = code;
    e.down  = down;
    e.shift = shift;
    e.alt   = alt;
    unique case (code)
      CH_CR:  e.code = CH_ENTER;
      CH_BS:  begin e.code = 7'h30; e.shift = 1'b1; end
      CH_DQ:  begin e.code = CH_P; e.alt = 1'b1; e.shift = 1'b0; end
      CH_TAB: begin e.code = CH_NONE; e.shift = 1'b1; e.alt = 1'b1; end
      7'h21:  e.code = 7'h31;  // ! -> 1
      7'h40:  e.code = 7'h32;  // @ -> 2
      7'h23:  e.code = 7'h33;  // # -> 3
      7'h24:  e.code = 7'h34;  // $ -> 4
      7'h25:  e.code = 7'h35;  // % -> 5
      7'h5e:  e.code = 7'h36;  // ^ -> 6
      7'h26:  e.code = 7'h37;  // & -> 7
      7'h2a:  e.code = 7'h38;  // * -> 8
      7'h28:  e.code = 7'h39;  // ( -> 9
      7'h29:  e.code = 7'h30;  // ) -> 0
      default: ;
    endcase
    return e;
  endfunction

  // Matrix position of a code; unmapped codes miss
  function automatic key_loc_t key_lookup(input logic [6:0] code);
    key_loc_t l;
    l = '0;
    unique case (code)
      7'h63: l = mk_loc(0, 0);  // c caps shift
      7'h5a: l = mk_loc(0, 1);  // Z
      7'h58: l = mk_loc(0, 2);  // X
      7'h43: l = mk_loc(0, 3);  // C
      7'h56: l = mk_loc(0, 4);  // V
      7'h41: l = mk_loc(1, 0);  // A
      7'h53: l = mk_loc(1, 1);  // S
      7'h44: l = mk_loc(1, 2);  // D
      7'h46: l = mk_loc(1, 3);  // F
      7'h47: l = mk_loc(1, 4);  // G
      7'h51: l = mk_loc(2, 0);  // Q
      7'h57: l = mk_loc(2, 1);  // W
      7'h45: l = mk_loc(2, 2);  // E
      7'h52: l = mk_loc(2, 3);  // R
      7'h54: l = mk_loc(2, 4);  // T
      7'h31: l = mk_loc(3, 0);  // 1
      7'h32: l = mk_loc(3, 1);  // 2
      7'h33: l = mk_loc(3, 2);  // 3
      7'h34: l = mk_loc(3, 3);  // 4
      7'h35: l = mk_loc(3, 4);  // 5
      7'h30: l = mk_loc(4, 0);  // 0
      7'h39: l = mk_loc(4, 1);  // 9
      7'h38: l = mk_loc(4, 2);  // 8
      7'h37: l = mk_loc(4, 3);  // 7
      7'h36: l = mk_loc(4, 4);  // 6
      7'h50: l = mk_loc(5, 0);  // P
      7'h4f: l = mk_loc(5, 1);  // O
      7'h49: l = mk_loc(5, 2);  // I
      7'h55: l = mk_loc(5, 3);  // U
      7'h59: l = mk_loc(5, 4);  // Y
      7'h65: l = mk_loc(6, 0);  // e enter
      7'h4c: l = mk_loc(6, 1);  // L
      7'h4b: l = mk_loc(6, 2);  // K
      7'h4a: l = mk_loc(6, 3);  // J
      7'h48: l = mk_loc(6, 4);  // H
      7'h20: l = mk_loc(7, 0);  // space
      7'h73: l = mk_loc(7, 1);  // s symbol shift
      7'h4d: l = mk_loc(7, 2);  // M
      7'h4e: l = mk_loc(7, 3);  // N
      7'h42: l = mk_loc(7, 4);  // B
      default: l = '0;
    endcase
    return l;
  endfunction

endpackage

// ===== sv/kmp_ifs.sv =====
// ----------------------------------------------------------------------------
// kmp channels
// Valid/ready channels for keyboard matrix port items and read results.
// ----------------------------------------------------------------------------
interface kmp_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [6:0]  key_code;
  logic        key_down;
  logic        shift_flag;
  logic        alt_flag;
  logic [15:0] port_address;

  modport source (output valid, opcode, key_code, key_down, shift_flag, alt_flag,
                  port_address, input ready);
  modport sink   (input valid, opcode, key_code, key_down, shift_flag, alt_flag,
                  port_address, output ready);
endinterface

interface kmp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

// ===== sv/kmp_matrix.sv =====
// ----------------------------------------------------------------------------
// kmp_matrix
// 8 x 5 active-low key matrix with key event update and row scan.
// ----------------------------------------------------------------------------
module kmp_matrix (
  input  logic                       clk,
  input  logic                       rst_n,
  input  kmp_pkg::key_event_t        evt,
  input  logic [kmp_pkg::ROWS-1:0]   scan,
  output logic [kmp_pkg::COLS-1:0]   cols
);

  logic [kmp_pkg::COLS-1:0] rows_r   [kmp_pkg::ROWS];
  logic [kmp_pkg::COLS-1:0] rows_nxt [kmp_pkg::ROWS];
  kmp_pkg::key_loc_t        loc;

  assign loc = kmp_pkg::key_lookup(evt.code);

  // Apply the key, then the shift keys, which take precedence
  always_comb begin
    for (int r = 0; r < kmp_pkg::ROWS; r++) begin
      rows_nxt[r] = rows_r[r];
      if (evt.valid) begin
        if (loc.hit && loc.row == kmp_pkg::ROW_W'(r)) begin
          rows_nxt[r][loc.col] = ~evt.down;
        end
        if (kmp_pkg::CAPS_ROW == kmp_pkg::ROW_W'(r)) begin
          if (!evt.down) begin
            rows_nxt[r][kmp_pkg::CAPS_COL] = 1'b1;
          end else if (evt.shift) begin
            rows_nxt[r][kmp_pkg::CAPS_COL] = 1'b0;
          end
        end
        if (kmp_pkg::SYM_ROW == kmp_pkg::ROW_W'(r)) begin
          if (!evt.down) begin
            rows_nxt[r][kmp_pkg::SYM_COL] = 1'b1;
          end else if (evt.alt) begin
            rows_nxt[r][kmp_pkg::SYM_COL] = 1'b0;
          end
        end
      end
    end
  end

  // Hold the matrix; reset releases every key
  always_ff @(posedge clk) begin
    for (int r = 0; r < kmp_pkg::ROWS; r++) begin
      if (!rst_n) begin
        rows_r[r] <= kmp_pkg::ROW_RELEASED;
      end else begin
        rows_r[r] <= rows_nxt[r];
      end
    end
  end

  // AND together every row whose scan bit is low
  always_comb begin
    cols = kmp_pkg::ROW_RELEASED;
    for (int r = 0; r < kmp_pkg::ROWS; r++) begin
      if (!scan[r]) begin
        cols = cols & rows_r[r];
      end
    end
  end

endmodule

// ===== sv/keyboard_matrix_port_unit.sv =====
// ----------------------------------------------------------------------------
// keyboard_matrix_port_unit
// Key matrix port: key events update an 8 x 5 matrix, port reads scan it.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake   | payload
//   ---------+-----+-------------+----------------------------------------------
//   in_ch    | in  | valid/ready | opcode, key_code, key_down, shift_flag,
//            |     |             | alt_flag, port_address
//   out_ch   | out | valid/ready | read_data
//
// One item a cycle unless a read waits: an item is held in the input register,
// where the key lookup and matrix update or row scan run, and a read then
// moves on to the result register. Reset (rst_n low, synchronous) releases
// every key and empties both stages. A read held in the input register waits
// only while the result register is full and not being taken; key events and
// odd-address reads never wait.
// ----------------------------------------------------------------------------
module keyboard_matrix_port_unit (
  input  logic             clk,
  input  logic             rst_n,
  kmp_in_if.sink           in_ch,
  kmp_out_if.source        out_ch
);

  logic                         s1_valid_r;
  logic                         s1_valid_nxt;
  kmp_pkg::in_item_t            s1_item_r;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic [7:0]                   out_data_r;
  logic                         s1_needs_out;
  logic                         out_free;
  logic                         s1_go;
  logic                         in_take;
  kmp_pkg::key_event_t          evt;
  logic [kmp_pkg::COLS-1:0]     cols;

  // Stage control
  assign s1_needs_out = (s1_item_r.opcode == kmp_pkg::OP_READ) && !s1_item_r.port_address[0];
  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_go        = s1_valid_r && (!s1_needs_out || out_free);
  assign in_ch.ready  = !s1_valid_r || s1_go;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);

  always_comb begin
    if (s1_go && s1_needs_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Translate the held key event; fire it only as the item leaves
  always_comb begin
    evt = kmp_pkg::translate(s1_item_r.key_code, s1_item_r.key_down,
                             s1_item_r.shift_flag, s1_item_r.alt_flag);
    evt.valid = s1_go && (s1_item_r.opcode == kmp_pkg::OP_KEY);
  end

  kmp_matrix u_matrix (
    .clk   (clk),
    .rst_n (rst_n),
    .evt   (evt),
    .scan  (s1_item_r.port_address[15:8]),
    .cols  (cols)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the input item and the read result
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.opcode       <= in_ch.opcode;
      s1_item_r.key_code     <= in_ch.key_code;
      s1_item_r.key_down     <= in_ch.key_down;
      s1_item_r.shift_flag   <= in_ch.shift_flag;
      s1_item_r.alt_flag     <= in_ch.alt_flag;
      s1_item_r.port_address <= in_ch.port_address;
    end
    if (s1_go && s1_needs_out) begin
      out_data_r <= {kmp_pkg::READ_TOP, cols};
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_data_r;

endmodule

// ===== bench/tb_keyboard_matrix_port_unit.sv =====
// ----------------------------------------------------------------------------
// tb_keyboard_matrix_port_unit
// Self-checking bench for the keyboard matrix port. Key events and port reads
// go in over the item channel; a local model of the 8 x 5 key matrix predicts
// each even-address read value, and every result taken from the output
// channel is checked against the oldest prediction. Both channels idle at
// random, the receiver holds off once for a long stretch, and the last phase
// runs at full rate.
// ----------------------------------------------------------------------------
module tb_keyboard_matrix_port_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_HALF      = 6;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned MAX_REPORTED  = 10;
  localparam int unsigned TYPING_ITEMS  = 1250;
  localparam int unsigned TOTAL_ITEMS   = 1850;
  localparam int unsigned DRAIN_CYCLES  = 10;

  // Matrix layout, row-major: position = row * COLS + column
  localparam string MATRIX_KEYS = "cZXCVASDFGQWERT1234509876POIUYeLKJH sMNB";
  // Shifted digit symbols and the digits they stand for
  localparam string DIGIT_SYMBOLS = "!@#$%^&*()";
  localparam string DIGIT_KEYS    = "1234567890";
  localparam logic [6:0] CAPS_KEY = 7'h63;  // 'c'
  localparam logic [6:0] SYM_KEY  = 7'h73;  // 's'

  logic clk;
  logic rst_n;

  kmp_in_if  in_ch ();
  kmp_out_if out_ch ();

  keyboard_matrix_port_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted matrix, active low, and the read values still owed by the block
  logic [kmp_pkg::COLS-1:0] key_matrix [kmp_pkg::ROWS];
  logic [7:0]               reads_due [$];

  bit          idle_en;
  int unsigned hold_len;
  int unsigned items_sent;
  int unsigned fail_count;
  int unsigned idle_cycles;

  // --------------------------------------------------------------------------
  // Matrix model
  // --------------------------------------------------------------------------

  function automatic int matrix_position(input logic [6:0] code);
    for (int i = 0; i < kmp_pkg::ROWS * kmp_pkg::COLS; i++) begin
      if (MATRIX_KEYS[i] == {1'b0, code})
        return i;
    end
    return -1;
  endfunction

  function automatic void set_matrix_key(input logic [6:0] code, input logic down);
    int pos;
    pos = matrix_position(code);
    if (code == kmp_pkg::CH_NONE || pos < 0)
      return;
    key_matrix[pos / kmp_pkg::COLS][pos % kmp_pkg::COLS] = ~down;
  endfunction

  // Translate the host code, then move the key and the two shift keys
  function automatic void predict_key_event(input logic [6:0] code, input logic down,
                                            input logic shift, input logic alt);
    logic [6:0] key;
    key = code;
    case (code)
      kmp_pkg::CH_CR:  key = kmp_pkg::CH_ENTER;
      kmp_pkg::CH_BS:  begin key = 7'h30; shift = 1'b1; end
      kmp_pkg::CH_DQ:  begin key = kmp_pkg::CH_P; alt = 1'b1; shift = 1'b0; end
      kmp_pkg::CH_TAB: begin key = kmp_pkg::CH_NONE; shift = 1'b1; alt = 1'b1; end
      default: begin
        for (int i = 0; i < 10; i++) begin
          if (DIGIT_SYMBOLS[i] == {1'b0, code})
            key = 7'(DIGIT_KEYS[i]);
        end
      end
    endcase
    set_matrix_key(key, down);
    if (down) begin
      if (shift)
        set_matrix_key(CAPS_KEY, 1'b1);
      if (alt)
        set_matrix_key(SYM_KEY, 1'b1);
    end else begin
      set_matrix_key(CAPS_KEY, 1'b0);
      set_matrix_key(SYM_KEY, 1'b0);
    end
  endfunction

  // AND every row whose select bit in the high byte is low
  function automatic logic [7:0] predict_port_read(input logic [15:0] addr);
    logic [7:0] value;
    value = {kmp_pkg::READ_TOP, kmp_pkg::ROW_RELEASED};
    for (int r = 0; r < kmp_pkg::ROWS; r++) begin
      if (!addr[8 + r])
        value &= {3'b111, key_matrix[r]};
    end
    return value;
  endfunction

  // --------------------------------------------------------------------------
  // Item builders
  // --------------------------------------------------------------------------

  function automatic kmp_pkg::in_item_t key_item(input logic [6:0] code, input logic down,
                                                 input logic shift, input logic alt);
    kmp_pkg::in_item_t it;
    it.opcode       = kmp_pkg::OP_KEY;
    it.key_code     = code;
    it.key_down     = down;
    it.shift_flag   = shift;
    it.alt_flag     = alt;
    it.port_address = 16'($urandom);
    return it;
  endfunction

  function automatic kmp_pkg::in_item_t read_item(input logic [15:0] addr);
    kmp_pkg::in_item_t it;
    it.opcode       = kmp_pkg::OP_READ;
    it.key_code     = 7'($urandom);
    it.key_down     = 1'($urandom);
    it.shift_flag   = 1'($urandom);
    it.alt_flag     = 1'($urandom);
    it.port_address = addr;
    return it;
  endfunction

  // Mostly even addresses that select one or a few rows
  function automatic logic [15:0] pick_read_address();
    logic [7:0] rows_sel;
    logic [7:0] low;
    low = 8'($urandom) & 8'hfe;
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1:       rows_sel = 8'hff;
      2:       rows_sel = 8'h00;
      3, 4:    rows_sel = 8'($urandom) | 8'($urandom);
      default: rows_sel = ~(8'h01 << $urandom_range(0, kmp_pkg::ROWS - 1));
    endcase
    return {rows_sel, low};
  endfunction

  // Mapped keys, shifted digits, the other translated codes and random codes
  function automatic logic [6:0] pick_typed_code();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 10)
      return 7'(MATRIX_KEYS[$urandom_range(0, kmp_pkg::ROWS * kmp_pkg::COLS - 1)]);
    case (r)
      10, 11, 12: return 7'(DIGIT_SYMBOLS[$urandom_range(0, 9)]);
      13:         return kmp_pkg::CH_CR;
      14:         return kmp_pkg::CH_BS;
      15:         return kmp_pkg::CH_DQ;
      16:         return kmp_pkg::CH_TAB;
      default:    return 7'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Sender: offer one item, wait for acceptance and update the model
  // --------------------------------------------------------------------------

  task automatic send_item(input kmp_pkg::in_item_t it);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= it.opcode;
    in_ch.key_code     <= it.key_code;
    in_ch.key_down     <= it.key_down;
    in_ch.shift_flag   <= it.shift_flag;
    in_ch.alt_flag     <= it.alt_flag;
    in_ch.port_address <= it.port_address;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (it.opcode == kmp_pkg::OP_KEY)
      predict_key_event(it.key_code, it.key_down, it.shift_flag, it.alt_flag);
    else if (!it.port_address[0])
      reads_due.push_back(predict_port_read(it.port_address));
    items_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, and one long hold on request
  // --------------------------------------------------------------------------

  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check against the oldest predicted read
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    logic [7:0] want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (reads_due.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTED)
          $display("unexpected read result: read_data=%02h", out_ch.read_data);
      end else begin
        want = reads_due.pop_front();
        if (out_ch.read_data !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTED)
            $display("read_data mismatch: expected %02h, actual %02h",
                     want, out_ch.read_data);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reads straight after reset: every key released, odd address ignored
  task automatic test_reset_state();
    send_item(read_item(16'h0000));
    send_item(read_item(16'hff00));
    send_item(read_item(16'h0001));
    send_item(read_item(16'h7ffe));
  endtask

  // The translated control codes, two shifted digits, the shift keys they add and the release of both
  task automatic test_translation();
    send_item(key_item(kmp_pkg::CH_CR, 1'b1, 1'b0, 1'b0));
    send_item(read_item(16'hbf00));
    send_item(key_item(kmp_pkg::CH_BS, 1'b1, 1'b0, 1'b0));
    send_item(read_item(16'hee00));
    send_item(key_item(kmp_pkg::CH_DQ, 1'b1, 1'b1, 1'b0));
    send_item(read_item(16'h5f00));
    send_item(key_item(kmp_pkg::CH_CR, 1'b0, 1'b1, 1'b1));
    send_item(read_item(16'h0000));
    send_item(key_item(kmp_pkg::CH_TAB, 1'b1, 1'b0, 1'b0));
    send_item(read_item(16'h7e00));
    send_item(key_item(7'h21, 1'b1, 1'b0, 1'b0));
    send_item(key_item(7'h29, 1'b1, 1'b0, 1'b0));
    send_item(read_item(16'he7fe));
  endtask

  // Unmapped codes leave the matrix alone but still move the shift keys
  task automatic test_unmapped_codes();
    send_item(key_item(7'h7f, 1'b1, 1'b0, 1'b1));
    send_item(key_item(7'h61, 1'b1, 1'b1, 1'b0));
    send_item(read_item(16'h0000));
    send_item(key_item(kmp_pkg::CH_NONE, 1'b0, 1'b1, 1'b1));
    send_item(read_item(16'h0002));
    send_item(key_item(CAPS_KEY, 1'b1, 1'b0, 1'b0));
    send_item(key_item(SYM_KEY, 1'b1, 1'b0, 1'b0));
    send_item(read_item(16'h7e00));
  endtask

  // One typed chord: one or two presses, one to three scans, then usually a release
  task automatic type_chord();
    logic [6:0] first;
    first = pick_typed_code();
    send_item(key_item(first, 1'b1, $urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0));
    if ($urandom_range(0, 2) == 0)
      send_item(key_item(pick_typed_code(), 1'b1, 1'($urandom), 1'($urandom)));
    repeat ($urandom_range(1, 3))
      send_item(read_item(pick_read_address()));
    if ($urandom_range(0, 4) != 0)
      send_item(key_item(($urandom_range(0, 3) == 0) ? pick_typed_code() : first,
                         1'b0, 1'($urandom), 1'($urandom)));
  endtask

  // Random items with no structure at all
  task automatic send_noise();
    kmp_pkg::in_item_t it;
    it.opcode       = 1'($urandom);
    it.key_code     = 7'($urandom);
    it.key_down     = 1'($urandom);
    it.shift_flag   = 1'($urandom);
    it.alt_flag     = 1'($urandom);
    it.port_address = 16'($urandom);
    send_item(it);
  endtask

  task automatic test_random_typing(input int unsigned upto);
    while (items_sent < upto) begin
      if ($urandom_range(0, 4) == 0)
        send_noise();
      else
        type_chord();
    end
  endtask

  // Hold the receiver off while reads keep coming, so the input stalls
  task automatic test_output_hold();
    idle_en  = 1'b0;
    hold_len = LONG_HOLD;
    repeat (40)
      send_item(read_item(pick_read_address() & 16'hfffe));
    idle_en = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.opcode        = kmp_pkg::OP_KEY;
    in_ch.key_code      = '0;
    in_ch.key_down      = 1'b0;
    in_ch.shift_flag    = 1'b0;
    in_ch.alt_flag      = 1'b0;
    in_ch.port_address  = '0;
    for (int r = 0; r < kmp_pkg::ROWS; r++)
      key_matrix[r] = kmp_pkg::ROW_RELEASED;
    idle_en     = 1'b1;
    hold_len    = 0;
    items_sent  = 0;
    fail_count  = 0;
    @(posedge rst_n);

    test_reset_state();
    test_translation();
    test_unmapped_codes();
    test_random_typing(TYPING_ITEMS);
    test_output_hold();
    idle_en = 1'b0;
    test_random_typing(TOTAL_ITEMS);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (reads_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && reads_due.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
